// File: hdl/servo_speed_frame_deframer_defines.svh
// assertion macros for the servo speed frame deframer
`ifndef SERVO_SPEED_FRAME_DEFRAMER_DEFINES_SVH
`define SERVO_SPEED_FRAME_DEFRAMER_DEFINES_SVH

// checked on clk_i, quiet while rst_ni is low
`define SSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i in and out of reset
`define SSFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/ssfd_pkg.sv
// shared types and constants of the servo speed frame deframer
`default_nettype none

package ssfd_pkg;

  localparam int unsigned FrameLen = 11;
  localparam logic [3:0] FrameLenW = 4'd11;
  localparam logic [3:0] LastPos = 4'd10;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadHeader = 3'd1,
    StLenLong   = 3'd2,
    StLenShort  = 3'd3,
    StBadTail   = 3'd4,
    StBadParity = 3'd5
  } status_e;

  typedef enum logic {
    CfgHeader = 1'b0,
    CfgTail   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    byte_t header;
    byte_t tail;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    byte_t              command;
    logic signed [15:0] speed_first;
    logic signed [15:0] speed_second;
    logic signed [15:0] speed_third;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/ssfd_byte_if.sv
// valid/ready channel carrying one received byte
`default_nettype none

interface ssfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/ssfd_result_if.sv
// valid/ready channel carrying one frame outcome
`default_nettype none

interface ssfd_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         command;
  logic signed [15:0] speed_first;
  logic signed [15:0] speed_second;
  logic signed [15:0] speed_third;

  modport source (
    output valid, output status, output command,
    output speed_first, output speed_second, output speed_third,
    input ready
  );
  modport sink (
    input valid, input status, input command,
    input speed_first, input speed_second, input speed_third,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/ssfd_in_stage.sv
// input register for received bytes
`default_nettype none

module ssfd_in_stage import ssfd_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  ssfd_byte_if.sink    rx_i,
  input  logic         take_i,
  output logic         vld_o,
  output byte_t        byte_o
);

  logic  vld_q;
  logic  vld_d;
  byte_t byte_q;

  assign rx_i.ready = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (rx_i.ready) begin
      vld_d = rx_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

// File: hdl/ssfd_window.sv
// 11-byte window, frame checks and front drop
`default_nettype none

`include "servo_speed_frame_deframer_defines.svh"

module ssfd_window import ssfd_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  logic    in_vld_i,
  input  byte_t   in_byte_i,
  input  cfg_t    cfg_i,
  input  logic    out_free_i,
  output logic    take_o,
  output logic    rslt_vld_o,
  output result_t rslt_o
);

  byte_t      win_q [FrameLen];
  byte_t      win_full [FrameLen];
  byte_t      win_sh [FrameLen];
  logic [4:0] src [FrameLen];
  logic [3:0] fill_q;
  logic [3:0] fill_d;
  logic [3:0] drop_n;
  logic       full;
  byte_t      parity;

  assign full   = (fill_q == LastPos);
  assign take_o = in_vld_i && (!full || out_free_i);
  assign rslt_vld_o = take_o && full;

  // place the new byte
  always_comb begin
    win_full = win_q;
    win_full[fill_q] = in_byte_i;
  end

  // frame checks in priority order
  always_comb begin
    rslt_o = '0;
    drop_n = FrameLenW;
    parity = '0;
    for (int i = 1; i <= 8; i++) begin
      parity = parity ^ win_full[i];
    end
    if (win_full[0] != cfg_i.header) begin
      rslt_o.status = StBadHeader;
      drop_n = 4'd1;
    end else if (win_full[1] > {4'd0, FrameLenW}) begin
      rslt_o.status = StLenLong;
    end else if (win_full[1] < {4'd0, FrameLenW}) begin
      rslt_o.status = StLenShort;
      drop_n = (win_full[1] == 8'd0) ? 4'd1 : win_full[1][3:0];
    end else if (win_full[10] != cfg_i.tail) begin
      rslt_o.status = StBadTail;
    end else if (parity != win_full[9]) begin
      rslt_o.status = StBadParity;
    end else begin
      rslt_o.status       = StOk;
      rslt_o.command      = win_full[2];
      rslt_o.speed_first  = {win_full[4], win_full[3]};
      rslt_o.speed_second = {win_full[6], win_full[5]};
      rslt_o.speed_third  = {win_full[8], win_full[7]};
    end
  end

  // move the remaining bytes to the front
  always_comb begin
    for (int k = 0; k < FrameLen; k++) begin
      src[k] = 5'(k) + {1'b0, drop_n};
      win_sh[k] = (src[k] < {1'b0, FrameLenW}) ? win_full[src[k][3:0]] : win_full[k];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (take_o) begin
      fill_d = full ? (FrameLenW - drop_n) : (fill_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      win_q <= full ? win_sh : win_full;
    end
  end

  `SSFD_ASSERT(a_fill_range, fill_q <= LastPos, "fill count beyond window")
  `SSFD_ASSERT(a_fill_step, (take_o && !full) |=> (fill_q == $past(fill_q) + 4'd1), "fill count did not advance")
  `SSFD_ASSERT(a_result_room, rslt_vld_o |-> out_free_i, "result produced with output stage busy")

endmodule

`default_nettype wire

// File: hdl/ssfd_out_stage.sv
// output register for frame outcomes
`default_nettype none

`include "servo_speed_frame_deframer_defines.svh"

module ssfd_out_stage import ssfd_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  logic          load_i,
  input  result_t       rslt_i,
  output logic          free_o,
  ssfd_result_if.source res_o
);

  logic    vld_q;
  logic    vld_d;
  result_t data_q;

  assign free_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= rslt_i;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.status       = data_q.status;
  assign res_o.command      = data_q.command;
  assign res_o.speed_first  = data_q.speed_first;
  assign res_o.speed_second = data_q.speed_second;
  assign res_o.speed_third  = data_q.speed_third;

  `SSFD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !vld_q || rst_ni, "output valid out of reset")

endmodule

`default_nettype wire

// File: hdl/servo_speed_frame_deframer.sv
// top level of the servo speed frame deframer
`default_nettype none

// Takes one received byte per clock into an 11-byte window; on each byte that
// fills the window the frame is checked (header, length, tail, XOR parity) and
// one outcome transaction is produced, after which the rejected or consumed
// bytes leave the front of the window. A byte passes the input register and
// the combinational window checks into the output register, which offers its
// outcome. Sustained rate is one byte per cycle; the only stall is a byte that
// completes the window while the output register holds an untaken outcome.
// header_byte (index 0, reset 0xAA) and tail_byte (index 1, reset 0x55) are
// the user's to write via the cfg port while idle; the block does not enforce it.

module servo_speed_frame_deframer import ssfd_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  ssfd_byte_if.sink     rx_i,
  ssfd_result_if.source res_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i
);

  cfg_t    cfg_q;
  cfg_t    cfg_d;
  logic    in_vld;
  byte_t   in_byte;
  logic    take;
  logic    out_free;
  logic    rslt_vld;
  result_t rslt;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgHeader: cfg_d.header = cfg_data_i;
        CfgTail:   cfg_d.tail = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header <= 8'hAA;
      cfg_q.tail   <= 8'h55;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssfd_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .take_i (take),
    .vld_o  (in_vld),
    .byte_o (in_byte)
  );

  ssfd_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_vld),
    .in_byte_i  (in_byte),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .take_o     (take),
    .rslt_vld_o (rslt_vld),
    .rslt_o     (rslt)
  );

  ssfd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (rslt_vld),
    .rslt_i (rslt),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// File: bench/servo_speed_frame_deframer_tb.sv
// self-checking testbench for the servo speed frame deframer: byte stream in, outcomes checked
`timescale 1ns / 1ps

module servo_speed_frame_deframer_tb import ssfd_pkg::*; ();

  localparam int unsigned PhaseBytes = 330;
  localparam int unsigned PhaseCount = 5;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxWait = 11;
  localparam byte_t ResetHeader = 8'haa;
  localparam byte_t ResetTail = 8'h55;
  localparam byte_t CmdSetAbc = 8'h01;
  localparam byte_t CmdSetDef = 8'h02;

  typedef enum int {
    FrGood,
    FrBadTail,
    FrBadParity,
    FrLenLong,
    FrLenShort,
    FrCut,
    FrNoise
  } frame_kind_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  ssfd_byte_if   rx_if ();
  ssfd_result_if res_if ();

  servo_speed_frame_deframer dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  byte_t       tx_bytes_q[$];
  result_t     outcome_q[$];
  byte_t       win[FrameLen];
  int unsigned win_fill = 0;
  cfg_t        cfg_now;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_gap;
  int unsigned src_burst;
  int unsigned snk_stall;
  int unsigned snk_burst;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // window model: push one byte, check the frame once the window is full
  function automatic bit deframe_byte(input byte_t b, output result_t r);
    byte_t       par;
    int unsigned n;
    int unsigned i;
    r = '0;
    if (win_fill >= FrameLen) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < FrameLen) return 1'b0;
    par = '0;
    for (i = 1; i <= 8; i++) par ^= win[i];
    n = FrameLen;
    if (win[0] != cfg_now.header) begin
      r.status = StBadHeader;
      n = 1;
    end else if (win[1] > FrameLen) begin
      r.status = StLenLong;
    end else if (win[1] < FrameLen) begin
      r.status = StLenShort;
      n = (win[1] == 0) ? 1 : win[1];
    end else if (win[10] != cfg_now.tail) begin
      r.status = StBadTail;
    end else if (par != win[9]) begin
      r.status = StBadParity;
    end else begin
      r.status = StOk;
      r.command = win[2];
      r.speed_first = {win[4], win[3]};
      r.speed_second = {win[6], win[5]};
      r.speed_third = {win[8], win[7]};
    end
    for (i = 0; i + n < FrameLen; i++) win[i] = win[i + n];
    win_fill = FrameLen - n;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_frame(input frame_kind_e kind);
    byte_t       f[FrameLen];
    logic [15:0] spd;
    int unsigned cut;
    int unsigned i;
    f[0] = cfg_now.header;
    f[1] = byte_t'(FrameLen);
    case ($urandom_range(0, 3))
      0: f[2] = CmdSetAbc;
      1: f[2] = CmdSetDef;
      default: f[2] = byte_t'($urandom);
    endcase
    for (i = 0; i < 3; i++) begin
      spd = pick_speed();
      f[3 + 2 * i] = spd[7:0];
      f[4 + 2 * i] = spd[15:8];
    end
    f[9] = '0;
    for (i = 1; i <= 8; i++) f[9] ^= f[i];
    f[10] = cfg_now.tail;
    case (kind)
      FrBadTail: f[10] ^= byte_t'($urandom_range(1, 255));
      FrBadParity: f[9] ^= byte_t'($urandom_range(1, 255));
      FrLenLong: f[1] = byte_t'($urandom_range(12, 255));
      FrLenShort: f[1] = byte_t'($urandom_range(0, 10));
      default: ;
    endcase
    if (kind == FrNoise) begin
      repeat ($urandom_range(1, 4)) tx_bytes_q.push_back(byte_t'($urandom));
    end else begin
      cut = (kind == FrCut) ? $urandom_range(1, 10) : FrameLen;
      for (i = 0; i < cut; i++) tx_bytes_q.push_back(f[i]);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input byte_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CfgHeader) cfg_now.header = val;
    else cfg_now.tail = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (tx_bytes_q.size() != 0 || rx_if.valid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph;
    int unsigned added;
    int unsigned before_sz;
    int unsigned pick;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgHeader;
    cfg_data_i = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    cfg_now.header = ResetHeader;
    cfg_now.tail = ResetTail;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // good frame with extreme speeds, then a header miss and a zero length
    tx_bytes_q = '{ResetHeader, byte_t'(FrameLen), CmdSetAbc, 8'h00, 8'h80, 8'hff, 8'h7f,
                   8'hff, 8'hff, 8'h0a, ResetTail,
                   8'h00, ResetHeader, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                   8'hff, 8'hff, 8'hff, 8'hff, 8'hff};

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        1: begin
          write_reg(CfgHeader, 8'h00);
          write_reg(CfgTail, 8'hff);
        end
        2: begin
          write_reg(CfgHeader, 8'hff);
          write_reg(CfgTail, 8'h00);
        end
        3: begin
          write_reg(CfgHeader, byte_t'($urandom));
          write_reg(CfgTail, byte_t'($urandom));
        end
        4: begin
          write_reg(CfgHeader, ResetHeader);
          write_reg(CfgTail, ResetTail);
        end
        default: ;
      endcase
      added = 0;
      while (added < PhaseBytes) begin
        before_sz = tx_bytes_q.size();
        pick = $urandom_range(0, 99);
        if (pick < 55) queue_frame(FrGood);
        else if (pick < 63) queue_frame(FrBadTail);
        else if (pick < 71) queue_frame(FrBadParity);
        else if (pick < 78) queue_frame(FrLenLong);
        else if (pick < 85) queue_frame(FrLenShort);
        else if (pick < 92) queue_frame(FrCut);
        else queue_frame(FrNoise);
        added += tx_bytes_q.size() - before_sz;
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("servo_speed_frame_deframer: match");
    end else begin
      $display("servo_speed_frame_deframer: mismatch");
    end
    $finish;
  end

  // byte source with random gaps and gap-free bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      src_gap <= 0;
      src_burst <= 0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (src_gap != 0) begin
        rx_if.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (tx_bytes_q.size() != 0) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= tx_bytes_q.pop_front();
        if (src_burst != 0) begin
          src_burst <= src_burst - 1;
          src_gap <= 0;
        end else begin
          src_gap <= $urandom_range(0, MaxWait);
          if ($urandom_range(0, 15) == 0) src_burst <= $urandom_range(8, 64);
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // outcome sink with random stalls and stall-free bursts
  always @(posedge clk_i) begin : sink_side
    int unsigned w;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_stall <= 0;
      snk_burst <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (snk_burst != 0) begin
        snk_burst <= snk_burst - 1;
        snk_stall <= 0;
        res_if.ready <= 1'b1;
      end else begin
        w = $urandom_range(0, MaxWait);
        res_if.ready <= (w == 0);
        snk_stall <= w;
        if ($urandom_range(0, 7) == 0) snk_burst <= $urandom_range(4, 24);
      end
    end else if (snk_stall > 1) begin
      snk_stall <= snk_stall - 1;
    end else begin
      snk_stall <= 0;
      res_if.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // predict on each byte transaction, compare on each outcome transaction
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        if (deframe_byte(rx_if.rx_byte, want)) outcome_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: status expected none got %0d", $time, res_if.status);
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 16'(want.status), 16'(res_if.status));
          check_field("command", 16'(want.command), 16'(res_if.command));
          check_field("speed_first", want.speed_first, res_if.speed_first);
          check_field("speed_second", want.speed_second, res_if.speed_second);
          check_field("speed_third", want.speed_third, res_if.speed_third);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("servo_speed_frame_deframer: mismatch");
      $finish;
    end
  end

endmodule
